[sv/oqd_pkg.sv]
// shared constants, types and helper functions of the ofdm qam hard demapper
`timescale 1ns / 1ps

package oqd_pkg;

  // field widths
  localparam int SAMPLE_W   = 16;
  localparam int RATE_W     = 4;
  localparam int LEN_W      = 16;
  localparam int BYTE_W     = 8;
  localparam int TOTAL_W    = 12;
  localparam int CARRIER_W  = 6;
  localparam int ACC_W      = 13;
  localparam int FILL_W     = 4;
  localparam int NSYM_W     = 16;
  localparam int NDBPS_W    = 8;
  localparam int BPS_W      = 6;
  localparam int BITS_W     = 6;
  localparam int CNT_W      = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // packet sizing
  localparam int MAX_DATA_BYTES  = 3024;
  localparam int SIGNAL_OVERHEAD = 22;  // 16 service bits plus 6 tail bits
  localparam int DIVIDEND_W      = 20;
  localparam int DIV_STEPS       = DIVIDEND_W;
  localparam int STEP_W          = $clog2(DIV_STEPS);
  localparam int PRODUCT_W       = NSYM_W + BPS_W;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_CODE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD_LENGTH = 2'd1;

  localparam logic [RATE_W-1:0] RATE_CODE_RESET = 4'd5;

  // signal field rate codes
  localparam logic [RATE_W-1:0] RATE_6M  = 4'd13;
  localparam logic [RATE_W-1:0] RATE_9M  = 4'd15;
  localparam logic [RATE_W-1:0] RATE_12M = 4'd5;
  localparam logic [RATE_W-1:0] RATE_18M = 4'd7;
  localparam logic [RATE_W-1:0] RATE_24M = 4'd9;
  localparam logic [RATE_W-1:0] RATE_36M = 4'd11;
  localparam logic [RATE_W-1:0] RATE_48M = 4'd1;
  localparam logic [RATE_W-1:0] RATE_54M = 4'd3;

  // subcarrier map in fft order
  localparam logic [CARRIER_W-1:0] FIRST_DATA_CARRIER = 6'd6;
  localparam logic [CARRIER_W-1:0] LAST_DATA_CARRIER  = 6'd58;
  localparam logic [CARRIER_W-1:0] PILOT_M21          = 6'd11;
  localparam logic [CARRIER_W-1:0] PILOT_M7           = 6'd25;
  localparam logic [CARRIER_W-1:0] DC_CARRIER         = 6'd32;
  localparam logic [CARRIER_W-1:0] PILOT_P7           = 6'd39;
  localparam logic [CARRIER_W-1:0] PILOT_P21          = 6'd53;

  // gray labels of the eight 64-qam levels per axis, lowest level first
  localparam logic [2:0] QAM64_GRAY [8] = '{3'd0, 3'd4, 3'd6, 3'd2, 3'd3, 3'd7, 3'd5, 3'd1};

  typedef enum logic [1:0] {
    MOD_BPSK,
    MOD_QPSK,
    MOD_QAM16,
    MOD_QAM64
  } oqd_mod_e;

  typedef struct packed {
    oqd_mod_e             modulation;
    logic [NDBPS_W-1:0]   ndbps;
    logic [BPS_W-1:0]     sym_bytes;
  } oqd_rate_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_DIV,
    ST_SCALE,
    ST_RUN
  } oqd_state_e;

  typedef struct packed {
    logic calc_load;
    logic calc_step;
    logic calc_scale;
    logic run;
  } oqd_ctrl_t;

  function automatic oqd_rate_t rate_info(input logic [RATE_W-1:0] code);
    oqd_rate_t ri;
    unique case (code)
      RATE_6M:  ri = '{modulation: MOD_BPSK,  ndbps: 8'd24,  sym_bytes: 6'd6};
      RATE_9M:  ri = '{modulation: MOD_BPSK,  ndbps: 8'd36,  sym_bytes: 6'd6};
      RATE_18M: ri = '{modulation: MOD_QPSK,  ndbps: 8'd72,  sym_bytes: 6'd12};
      RATE_24M: ri = '{modulation: MOD_QAM16, ndbps: 8'd96,  sym_bytes: 6'd24};
      RATE_36M: ri = '{modulation: MOD_QAM16, ndbps: 8'd144, sym_bytes: 6'd24};
      RATE_48M: ri = '{modulation: MOD_QAM64, ndbps: 8'd192, sym_bytes: 6'd36};
      RATE_54M: ri = '{modulation: MOD_QAM64, ndbps: 8'd216, sym_bytes: 6'd36};
      default:  ri = '{modulation: MOD_QPSK,  ndbps: 8'd48,  sym_bytes: 6'd12};
    endcase
    return ri;
  endfunction

  function automatic logic is_data_carrier(input logic [CARRIER_W-1:0] c);
    return (c >= FIRST_DATA_CARRIER) && (c <= LAST_DATA_CARRIER) &&
           !((c == PILOT_M21) || (c == PILOT_M7) || (c == DC_CARRIER) ||
             (c == PILOT_P7) || (c == PILOT_P21));
  endfunction

endpackage

[sv/oqd_intf.sv]
// handshake channels of the ofdm qam hard demapper: samples, bytes, configuration
`timescale 1ns / 1ps

interface oqd_smp_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [oqd_pkg::SAMPLE_W-1:0]   i_sample;
  logic signed [oqd_pkg::SAMPLE_W-1:0]   q_sample;
  logic                                  start_packet;

  modport source (output valid, i_sample, q_sample, start_packet, input ready);
  modport sink   (input valid, i_sample, q_sample, start_packet, output ready);
endinterface

interface oqd_byte_if;
  logic                           valid;
  logic                           ready;
  logic [oqd_pkg::BYTE_W-1:0]     out_byte;
  logic                           from_signal;
  logic                           last_byte;
  logic [oqd_pkg::TOTAL_W-1:0]    byte_total;

  modport source (output valid, out_byte, from_signal, last_byte, byte_total, input ready);
  modport sink   (input valid, out_byte, from_signal, last_byte, byte_total, output ready);
endinterface

interface oqd_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [oqd_pkg::CFG_IDX_W-1:0]    index;
  logic [oqd_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[sv/oqd_ctrl.sv]
// sequencer: symbol count precompute after reset and configuration writes, then run
`timescale 1ns / 1ps

module oqd_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_wr_i,
  output oqd_pkg::oqd_ctrl_t ctrl_o
);
  import oqd_pkg::*;

  oqd_state_e          state_q, state_d;
  logic [STEP_W-1:0]   step_q, step_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    unique case (state_q)
      ST_LOAD: begin
        state_d = ST_DIV;
        step_d  = '0;
      end
      ST_DIV: begin
        step_d = step_q + 1'b1;
        if (step_q == STEP_W'(DIV_STEPS - 1)) begin
          state_d = ST_SCALE;
        end
      end
      ST_SCALE: state_d = ST_RUN;
      ST_RUN:   state_d = ST_RUN;
      default:  state_d = ST_LOAD;
    endcase
    // every configuration write restarts the precompute
    if (cfg_wr_i) begin
      state_d = ST_LOAD;
    end
  end

  // outputs
  always_comb begin
    ctrl_o = '0;
    unique case (state_q)
      ST_LOAD:  ctrl_o.calc_load  = 1'b1;
      ST_DIV:   ctrl_o.calc_step  = 1'b1;
      ST_SCALE: ctrl_o.calc_scale = 1'b1;
      ST_RUN:   ctrl_o.run        = 1'b1;
      default:  ctrl_o = '0;
    endcase
  end

endmodule

[sv/oqd_calc.sv]
// configuration registers and the serial divider that sizes the next packet
`timescale 1ns / 1ps

module oqd_calc (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  oqd_pkg::oqd_ctrl_t             ctrl_i,
  oqd_cfg_if.sink                        cfg_i,
  output logic [oqd_pkg::RATE_W-1:0]     rate_code_o,
  output logic [oqd_pkg::NSYM_W-1:0]     nsym_o,
  output logic [oqd_pkg::TOTAL_W-1:0]    total_o
);
  import oqd_pkg::*;

  logic [RATE_W-1:0]      rate_code_q;
  logic [LEN_W-1:0]       payload_length_q;

  logic [DIVIDEND_W-1:0]  dividend_q;
  logic [NDBPS_W-1:0]     divisor_q;
  logic [BPS_W-1:0]       bps_q;
  logic [NDBPS_W-1:0]     rem_q;
  logic [DIVIDEND_W-1:0]  quo_q;
  logic [NSYM_W-1:0]      nsym_q;
  logic [TOTAL_W-1:0]     total_q;

  oqd_rate_t              rinfo;
  logic [NDBPS_W:0]       rem_shift;
  logic                   rem_ge;
  logic [PRODUCT_W-1:0]   product;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_code_q      <= RATE_CODE_RESET;
      payload_length_q <= '0;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == CFG_RATE_CODE) begin
        rate_code_q <= cfg_i.data[RATE_W-1:0];
      end else if (cfg_i.index == CFG_PAYLOAD_LENGTH) begin
        payload_length_q <= cfg_i.data[LEN_W-1:0];
      end
    end
  end

  always_comb begin
    rinfo     = rate_info(rate_code_q);
    rem_shift = {rem_q, dividend_q[DIVIDEND_W-1]};
    rem_ge    = rem_shift >= {1'b0, divisor_q};
    product   = PRODUCT_W'(quo_q[NSYM_W-1:0]) * PRODUCT_W'(bps_q);
  end

  // ceil(bits / ndbps) as floor((bits + ndbps - 1) / ndbps), one quotient bit a cycle
  always_ff @(posedge clk_i) begin
    if (ctrl_i.calc_load) begin
      dividend_q <= (DIVIDEND_W'(payload_length_q) << 3) + DIVIDEND_W'(rinfo.ndbps) +
                    DIVIDEND_W'(SIGNAL_OVERHEAD - 1);
      divisor_q  <= rinfo.ndbps;
      bps_q      <= rinfo.sym_bytes;
      rem_q      <= '0;
      quo_q      <= '0;
    end else if (ctrl_i.calc_step) begin
      dividend_q <= dividend_q << 1;
      rem_q      <= rem_ge ? NDBPS_W'(rem_shift - {1'b0, divisor_q}) : NDBPS_W'(rem_shift);
      quo_q      <= {quo_q[DIVIDEND_W-2:0], rem_ge};
    end
    if (ctrl_i.calc_scale) begin
      nsym_q  <= quo_q[NSYM_W-1:0];
      total_q <= (product > PRODUCT_W'(MAX_DATA_BYTES)) ? TOTAL_W'(MAX_DATA_BYTES)
                                                        : product[TOTAL_W-1:0];
    end
  end

  assign rate_code_o = rate_code_q;
  assign nsym_o      = nsym_q;
  assign total_o     = total_q;

endmodule

[sv/oqd_demap.sv]
// per-subcarrier hard decision, bit packing and packet bookkeeping with output register
`timescale 1ns / 1ps

module oqd_demap (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  oqd_pkg::oqd_ctrl_t             ctrl_i,
  input  logic [oqd_pkg::RATE_W-1:0]     rate_code_i,
  input  logic [oqd_pkg::NSYM_W-1:0]     nsym_i,
  input  logic [oqd_pkg::TOTAL_W-1:0]    total_i,
  oqd_smp_if.sink                        smp_i,
  oqd_byte_if.source                     byte_o
);
  import oqd_pkg::*;

  // 16-qam axis: 3*s against -65534, 0, 65534
  function automatic logic [1:0] axis16(input logic signed [SAMPLE_W-1:0] s);
    logic signed [SAMPLE_W+1:0] sx;
    logic signed [SAMPLE_W+1:0] x;
    logic [1:0]                 r;
    sx = (SAMPLE_W+2)'(s);
    x  = sx + (sx <<< 1);
    if (x < -18'sd65534) begin
      r = 2'd0;
    end else if (x < 18'sd0) begin
      r = 2'd2;
    end else if (x < 18'sd65534) begin
      r = 2'd3;
    end else begin
      r = 2'd1;
    end
    return r;
  endfunction

  // 64-qam axis: 7*s against even multiples of full scale
  function automatic logic [2:0] axis64(input logic signed [SAMPLE_W-1:0] s);
    logic signed [SAMPLE_W+3:0] sx;
    logic signed [SAMPLE_W+3:0] x;
    logic signed [SAMPLE_W+3:0] th;
    logic [2:0]                 k;
    sx = (SAMPLE_W+4)'(s);
    x  = (sx <<< 3) - sx;
    k  = '0;
    for (int j = 0; j < 7; j++) begin
      th = (SAMPLE_W+4)'((2 * j - 6) * 32767);
      if (x >= th) begin
        k = k + 1'b1;
      end
    end
    return QAM64_GRAY[k];
  endfunction

  logic [CARRIER_W-1:0]  ci_q;
  logic                  sig_q;
  logic                  act_q;
  logic [NSYM_W-1:0]     syml_q;
  logic [ACC_W-1:0]      acc_q;
  logic [FILL_W-1:0]     fill_q;
  logic [TOTAL_W-1:0]    brem_q;
  logic [TOTAL_W-1:0]    blim_q;

  logic [CARRIER_W-1:0]  ci_b, ci_d;
  logic                  sig_b, sig_d;
  logic                  act_b, act_d;
  logic [NSYM_W-1:0]     syml_b, syml_d;
  logic [ACC_W-1:0]      acc_b, acc_m, acc_d;
  logic [FILL_W-1:0]     fill_b, fill_m, fill_d;
  logic [TOTAL_W-1:0]    brem_b, brem_d;
  logic [TOTAL_W-1:0]    blim_b;

  oqd_rate_t             rinfo;
  oqd_mod_e              modulation;
  logic                  data_carrier;
  logic [BITS_W-1:0]     bits;
  logic [CNT_W-1:0]      cnt;
  logic                  emit;
  logic                  result;
  logic                  last;
  logic                  fire;

  logic                  out_valid_q;
  logic [BYTE_W-1:0]     out_byte_q;
  logic                  from_signal_q;
  logic                  last_byte_q;
  logic [TOTAL_W-1:0]    byte_total_q;

  assign fire        = smp_i.valid && smp_i.ready;
  assign smp_i.ready = ctrl_i.run && (!out_valid_q || byte_o.ready);

  always_comb begin
    // a start marker resets the packet state before this sample is used
    if (smp_i.start_packet) begin
      ci_b   = '0;
      sig_b  = 1'b1;
      act_b  = 1'b1;
      syml_b = nsym_i;
      blim_b = total_i;
      brem_b = total_i;
      acc_b  = '0;
      fill_b = '0;
    end else begin
      ci_b   = ci_q;
      sig_b  = sig_q;
      act_b  = act_q;
      syml_b = syml_q;
      blim_b = blim_q;
      brem_b = brem_q;
      acc_b  = acc_q;
      fill_b = fill_q;
    end

    rinfo        = rate_info(rate_code_i);
    modulation   = sig_b ? MOD_BPSK : rinfo.modulation;
    data_carrier = is_data_carrier(ci_b);

    unique case (modulation)
      MOD_BPSK: begin
        bits = {5'b0, !smp_i.i_sample[SAMPLE_W-1]};
        cnt  = 3'd1;
      end
      MOD_QPSK: begin
        bits = {4'b0, !smp_i.q_sample[SAMPLE_W-1], !smp_i.i_sample[SAMPLE_W-1]};
        cnt  = 3'd2;
      end
      MOD_QAM16: begin
        bits = {2'b0, axis16(smp_i.q_sample), axis16(smp_i.i_sample)};
        cnt  = 3'd4;
      end
      MOD_QAM64: begin
        bits = {axis64(smp_i.q_sample), axis64(smp_i.i_sample)};
        cnt  = 3'd6;
      end
      default: begin
        bits = '0;
        cnt  = '0;
      end
    endcase

    acc_m  = data_carrier ? (acc_b | (ACC_W'(bits) << fill_b)) : acc_b;
    fill_m = data_carrier ? (fill_b + FILL_W'(cnt)) : fill_b;

    emit   = fill_m >= FILL_W'(BYTE_W);
    acc_d  = emit ? (acc_m >> BYTE_W) : acc_m;
    fill_d = emit ? (fill_m - FILL_W'(BYTE_W)) : fill_m;

    // signal bytes always go out, data bytes only up to the clamped total
    result = emit && (sig_b || (brem_b != '0));
    last   = !sig_b && (brem_b == TOTAL_W'(1));
    brem_d = (emit && !sig_b && (brem_b != '0)) ? (brem_b - 1'b1) : brem_b;

    ci_d   = ci_b + 1'b1;
    sig_d  = sig_b;
    act_d  = act_b;
    syml_d = syml_b;
    if (ci_b == '1) begin
      if (sig_b) begin
        sig_d = 1'b0;
        if (syml_b == '0) begin
          act_d = 1'b0;
        end
      end else begin
        if (syml_b != '0) begin
          syml_d = syml_b - 1'b1;
        end
        if (syml_d == '0) begin
          act_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ci_q   <= '0;
      sig_q  <= 1'b0;
      act_q  <= 1'b0;
      syml_q <= '0;
      acc_q  <= '0;
      fill_q <= '0;
      brem_q <= '0;
      blim_q <= '0;
    end else if (fire && act_b) begin
      ci_q   <= ci_d;
      sig_q  <= sig_d;
      act_q  <= act_d;
      syml_q <= syml_d;
      acc_q  <= acc_d;
      fill_q <= fill_d;
      brem_q <= brem_d;
      blim_q <= blim_b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire && act_b && result) begin
      out_valid_q <= 1'b1;
    end else if (byte_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && act_b && result) begin
      out_byte_q    <= acc_m[BYTE_W-1:0];
      from_signal_q <= sig_b;
      last_byte_q   <= last;
      byte_total_q  <= blim_b;
    end
  end

  assign byte_o.valid       = out_valid_q;
  assign byte_o.out_byte    = out_byte_q;
  assign byte_o.from_signal = from_signal_q;
  assign byte_o.last_byte   = last_byte_q;
  assign byte_o.byte_total  = byte_total_q;

endmodule

[sv/ofdm_qam_hard_demapper.sv]
// top level of the ofdm qam hard demapper
`timescale 1ns / 1ps

// Hard-decision demapper for 802.11a-style OFDM. Samples enter one subcarrier per
// transaction in fft order 0..63; only the 48 data subcarriers contribute bits. A
// sample with start_packet set opens a packet: its first symbol is SIGNAL (BPSK, six
// bytes flagged from_signal), the following symbols use the modulation of rate_code
// (unknown codes run as QPSK). Bits are packed LSB first, I before Q. The data
// symbol count ceil((22 + 8*payload_length)/NDBPS) and the byte total (clamped to
// 3024) are latched at start_packet; data bytes beyond the total are dropped and
// last_byte marks the final one. Throughput is one sample per clock while running,
// limited only by the single output register: a sample is taken whenever the
// output is empty or its byte is taken in the same cycle. After reset and after
// every configuration write the sample input is held off while the sequencer
// runs its load step, the bit-serial divider that computes the symbol count and
// its scaling step; configuration writes themselves are taken every cycle.

module ofdm_qam_hard_demapper (
  input  logic        clk_i,
  input  logic        rst_ni,
  oqd_cfg_if.sink     cfg_i,
  oqd_smp_if.sink     smp_i,
  oqd_byte_if.source  byte_o
);
  import oqd_pkg::*;

  oqd_ctrl_t              ctrl;
  logic                   cfg_wr;
  logic [RATE_W-1:0]      rate_code;
  logic [NSYM_W-1:0]      nsym;
  logic [TOTAL_W-1:0]     total;

  // every completed configuration transaction restarts the packet sizing
  assign cfg_wr = cfg_i.valid && cfg_i.ready;

  oqd_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_wr_i (cfg_wr),
    .ctrl_o   (ctrl)
  );

  // register file plus divider; nsym and total are stable once the sequencer runs
  oqd_calc u_calc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .cfg_i       (cfg_i),
    .rate_code_o (rate_code),
    .nsym_o      (nsym),
    .total_o     (total)
  );

  // sample path: decision, packing, byte counting and the output register
  oqd_demap u_demap (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .rate_code_i (rate_code),
    .nsym_i      (nsym),
    .total_i     (total),
    .smp_i       (smp_i),
    .byte_o      (byte_o)
  );

endmodule
